// ===== sv/soc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the substring occurrence counter.
// Used by every module of the block; it depends on nothing else.
package soc_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int TEXT_MAX    = 4096;

  // Derived widths and depths.
  localparam int WIN_DEPTH = PATTERN_MAX - 1;
  localparam int SEL_W     = $clog2(PATTERN_MAX);
  localparam int LEN_W     = 5;
  localparam int POS_W     = $clog2(TEXT_MAX) + 1;
  localparam int START_W   = $clog2(TEXT_MAX);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

  localparam logic [POS_W-1:0]   TEXT_LIMIT = POS_W'(TEXT_MAX);
  localparam logic [START_W-1:0] START_MAX  = START_W'(TEXT_MAX - 1);

  typedef logic [7:0]                  byte_t;
  typedef byte_t [WIN_DEPTH-1:0]       window_t;
  typedef byte_t [PATTERN_MAX-1:0]     pattern_t;
  typedef logic [LEN_W-1:0]            len_t;
  typedef logic [POS_W-1:0]            pos_t;
  typedef logic [START_W-1:0]          start_t;

endpackage

// ===== sv/soc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for text bytes in and match results out.
// Depends on soc_pkg for field widths.
interface soc_in_if;
  logic               valid;
  logic               ready;
  soc_pkg::byte_t     text_byte;
  logic               text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

interface soc_out_if;
  logic               valid;
  logic               ready;
  logic               match_here;
  soc_pkg::start_t    match_start;
  soc_pkg::pos_t      match_count;
  logic               record_done;

  modport source (output valid, output match_here, output match_start,
                  output match_count, output record_done, input ready);
  modport sink   (input valid, input match_here, input match_start,
                  input match_count, input record_done, output ready);
endinterface

// ===== sv/soc_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration registers: pattern length and the sixteen pattern bytes.
// Depends on soc_pkg.
module soc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [soc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [soc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output soc_pkg::len_t                     len_eff,
  output soc_pkg::pattern_t                 pattern
);

  soc_pkg::len_t                  pattern_length_r;
  logic [soc_pkg::CFG_DATA_W-1:0] pattern_low_r;
  logic [soc_pkg::CFG_DATA_W-1:0] pattern_high_r;

  // Register writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= soc_pkg::LEN_W'(1);
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        soc_pkg::REG_PATTERN_LENGTH: begin
          pattern_length_r <= cfg_wdata[soc_pkg::LEN_W-1:0];
        end
        soc_pkg::REG_PATTERN_LOW: begin
          pattern_low_r <= cfg_wdata;
        end
        soc_pkg::REG_PATTERN_HIGH: begin
          pattern_high_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Zero acts as one, and anything beyond the pattern capacity acts as full.
  always_comb begin
    if (pattern_length_r == '0) begin
      len_eff = soc_pkg::LEN_W'(1);
    end else if (pattern_length_r > soc_pkg::LEN_W'(soc_pkg::PATTERN_MAX)) begin
      len_eff = soc_pkg::LEN_W'(soc_pkg::PATTERN_MAX);
    end else begin
      len_eff = pattern_length_r;
    end
  end

  // Split the two words into bytes, byte 0 in the low bits.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pattern[k]     = pattern_low_r[k*8 +: 8];
      pattern[k + 8] = pattern_high_r[k*8 +: 8];
    end
  end

endmodule

// ===== sv/soc_window_cmp.sv =====
`timescale 1ns / 1ps
// Parallel compare of the newest text bytes against the active pattern.
// Depends on soc_pkg.
module soc_window_cmp (
  input  soc_pkg::byte_t    cur_byte,
  input  soc_pkg::window_t  window,
  input  soc_pkg::pattern_t pattern,
  input  soc_pkg::len_t     len_eff,
  output logic              window_match
);

  // Text bytes by distance back from the current byte.
  soc_pkg::byte_t [soc_pkg::PATTERN_MAX-1:0] text_tap;
  logic [soc_pkg::PATTERN_MAX-1:0]           byte_ok;
  logic [soc_pkg::SEL_W-1:0]                 tap_sel [soc_pkg::PATTERN_MAX];

  always_comb begin
    text_tap[0] = cur_byte;
    for (int d = 1; d < soc_pkg::PATTERN_MAX; d++) begin
      text_tap[d] = window[d - 1];
    end
  end

  // Pattern byte k lines up with the text byte len-1-k positions back.
  always_comb begin
    for (int k = 0; k < soc_pkg::PATTERN_MAX; k++) begin
      tap_sel[k] = soc_pkg::SEL_W'(len_eff - soc_pkg::LEN_W'(k) - soc_pkg::LEN_W'(1));
      if (soc_pkg::LEN_W'(k) < len_eff) begin
        byte_ok[k] = (text_tap[tap_sel[k]] == pattern[k]);
      end else begin
        byte_ok[k] = 1'b1;
      end
    end
  end

  assign window_match = &byte_ok;

endmodule

// ===== sv/substring_occurrence_counter_core.sv =====
`timescale 1ns / 1ps
// Substring occurrence counter: flags every pattern occurrence in a byte stream.
// A byte passes through the input stage register and then the result register.
// One byte per cycle unless out_if stalls; the single window-compare stage sets it.
// Reset (synchronous, rst_n low) empties both stages, clears the window, position
// and count, and sets the pattern length to one with all pattern bytes zero.
// Depends on soc_pkg, soc_if, soc_cfg_regs and soc_window_cmp.
module substring_occurrence_counter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  soc_in_if.sink                            in_if,
  soc_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [soc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [soc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  soc_pkg::len_t     len_eff;
  soc_pkg::pattern_t pattern;

  // Input stage.
  logic              s1_valid_r;
  soc_pkg::byte_t    s1_byte_r;
  logic              s1_last_r;

  // Record state.
  soc_pkg::window_t  window_r;
  soc_pkg::pos_t     pos_r;
  soc_pkg::pos_t     count_r;

  // Result stage.
  logic              out_valid_r;
  logic              match_here_r;
  soc_pkg::start_t   match_start_r;
  soc_pkg::pos_t     match_count_r;
  logic              record_done_r;

  logic                        in_xfer;
  logic                        advance;
  logic                        window_match;
  logic [soc_pkg::POS_W:0]     pos_plus1;
  logic [soc_pkg::POS_W:0]     start_full;
  logic                        hit;
  soc_pkg::start_t             start_nxt;
  soc_pkg::pos_t               count_nxt;

  soc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .len_eff   (len_eff),
    .pattern   (pattern)
  );

  soc_window_cmp u_cmp (
    .cur_byte     (s1_byte_r),
    .window       (window_r),
    .pattern      (pattern),
    .len_eff      (len_eff),
    .window_match (window_match)
  );

  // Handshake: a held input byte moves on when the result slot is free or being read.
  assign advance      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || advance;
  assign in_xfer      = in_if.valid && in_if.ready;

  // A match needs at least a pattern's worth of record bytes.
  always_comb begin
    pos_plus1  = {1'b0, pos_r} + (soc_pkg::POS_W + 1)'(1);
    hit        = window_match &&
                 (pos_plus1 >= (soc_pkg::POS_W + 1)'(len_eff));
    start_full = pos_plus1 - (soc_pkg::POS_W + 1)'(len_eff);
    start_nxt  = '0;
    if (hit) begin
      if (start_full > (soc_pkg::POS_W + 1)'(soc_pkg::START_MAX)) begin
        start_nxt = soc_pkg::START_MAX;
      end else begin
        start_nxt = start_full[soc_pkg::START_W-1:0];
      end
    end
    count_nxt = count_r;
    if (hit && (count_r < soc_pkg::TEXT_LIMIT)) begin
      count_nxt = count_r + soc_pkg::POS_W'(1);
    end
  end

  // Input stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_if.text_byte;
      s1_last_r <= in_if.text_last;
    end
  end

  // Record state: shift in the byte, or clear after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      pos_r    <= '0;
      count_r  <= '0;
    end else if (advance) begin
      if (s1_last_r) begin
        window_r <= '0;
        pos_r    <= '0;
        count_r  <= '0;
      end else begin
        for (int j = soc_pkg::WIN_DEPTH - 1; j > 0; j--) begin
          window_r[j] <= window_r[j - 1];
        end
        window_r[0] <= s1_byte_r;
        if (pos_r < soc_pkg::TEXT_LIMIT) begin
          pos_r <= pos_r + soc_pkg::POS_W'(1);
        end
        count_r <= count_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      match_here_r  <= hit;
      match_start_r <= start_nxt;
      match_count_r <= count_nxt;
      record_done_r <= s1_last_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.match_here  = match_here_r;
  assign out_if.match_start = match_start_r;
  assign out_if.match_count = match_count_r;
  assign out_if.record_done = record_done_r;

endmodule
